@@ rtl/icl_pkg.sv @@
// Shared types and constants for the iNES cartridge loader.
// Depends on nothing; used by the top level and its port checker.
`timescale 1ns / 1ps
`default_nettype none

package icl_pkg;

   localparam int HEADER_BYTES   = 16;
   localparam int PRG_BANK_SHIFT = 14;
   localparam int CHR_BANK_SHIFT = 13;
   localparam int POS_WIDTH      = 24;
   localparam int READ_WIDTH     = 17;

   localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

   localparam logic [7:0] TAG_BYTES [4] = '{8'h4E, 8'h45, 8'h53, 8'h1A};

   localparam logic [7:0] MAPPER_HI_MASK = 8'hF0;
   localparam logic [1:0] NES2_CODE_MASK = 2'h3;
   localparam logic [7:0] FOUR_SCREEN_BIT = 8'h08;
   localparam logic [7:0] VERTICAL_BIT    = 8'h01;
   localparam logic [7:0] TRAINER_BIT     = 8'h04;

   localparam logic [1:0] CMD_LOAD     = 2'd0;
   localparam logic [1:0] CMD_READ_PRG = 2'd1;
   localparam logic [1:0] CMD_READ_CHR = 2'd2;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_TAG    = 3'd1;
   localparam logic [2:0] ST_NES2       = 3'd2;
   localparam logic [2:0] ST_TRAINER    = 3'd3;
   localparam logic [2:0] ST_NO_PRG     = 3'd4;
   localparam logic [2:0] ST_TOO_SHORT  = 3'd5;
   localparam logic [2:0] ST_TOO_LARGE  = 3'd6;
   localparam logic [2:0] ST_ADDR_RANGE = 3'd7;

   localparam logic [1:0] MIRROR_HORIZONTAL  = 2'd0;
   localparam logic [1:0] MIRROR_VERTICAL    = 2'd1;
   localparam logic [1:0] MIRROR_FOUR_SCREEN = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  data_byte;
      logic        last;
      logic [15:0] address;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] mapper_number;
      logic [1:0] mirroring;
      logic [7:0] prg_bank_count;
      logic [7:0] chr_bank_count;
      logic [7:0] read_value;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/ines_cartridge_loader.sv @@
// A result item is registered in result stage A and then in stage B before it leaves.
// Throughput: one item per cycle; req_stall rises only when both result stages
// are full and rsp_stall is high. PRG and CHR store reads are registered alongside stage A.
// Reset: synchronous; clears load state, loaded bank counts and result valids.
// Store contents are not cleared and need no clearing pass.
// Top level of the iNES cartridge loader; depends on icl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ines_cartridge_loader #(
   parameter int MAX_PRG_BANKS = 2,
   parameter int MAX_CHR_BANKS = 1
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  icl_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output icl_pkg::rsp_type rsp_payload
);

   localparam int PRG_DEPTH = MAX_PRG_BANKS << icl_pkg::PRG_BANK_SHIFT;
   localparam int CHR_DEPTH = (MAX_CHR_BANKS == 0) ? 1 :
                              (MAX_CHR_BANKS << icl_pkg::CHR_BANK_SHIFT);
   localparam int PRG_AW = $clog2(PRG_DEPTH);
   localparam int CHR_AW = (CHR_DEPTH > 1) ? $clog2(CHR_DEPTH) : 1;
   localparam int LPW = $clog2(MAX_PRG_BANKS + 1);
   localparam int LCW = (MAX_CHR_BANKS == 0) ? 1 : $clog2(MAX_CHR_BANKS + 1);
   localparam int PW = icl_pkg::POS_WIDTH;
   localparam int RW = icl_pkg::READ_WIDTH;

   logic [7:0] prg_mem [PRG_DEPTH];
   logic [7:0] chr_mem [CHR_DEPTH];

   logic [PW-1:0]  pos_ff, pos_in;
   logic           loading_ff, loading_in;
   logic [7:0]     hdr_ff [4];
   logic [7:0]     hdr_in [4];
   logic           tag_ff, tag_in;
   logic [LPW-1:0] lprg_ff, lprg_in;
   logic [LCW-1:0] lchr_ff, lchr_in;

   logic             a_valid_ff, a_valid_in;
   icl_pkg::rsp_type a_rsp_ff, a_rsp_in;
   logic             a_prg_ok_ff, a_chr_ok_ff;
   logic [7:0]       prg_rd_ff, chr_rd_ff;
   logic             b_valid_ff, b_valid_in;
   icl_pkg::rsp_type b_rsp_ff, b_rsp_in;

   logic          accept, is_load, has_rsp, a_move;
   logic [PW-1:0] cur_pos, off, coff, prg_bytes, chr_bytes, total;
   logic [7:0]    cur_hdr [4];
   logic          cur_tag;
   logic          prg_wr, chr_wr;
   logic [2:0]    load_status;
   logic [15:0]   prg_eff;
   logic [RW-1:0] prg_limit, chr_limit;
   logic          prg_ok, chr_ok;
   logic [7:0]    a_read_value;

   always_comb begin
      accept  = req_valid && !req_stall;
      is_load = req_payload.command == icl_pkg::CMD_LOAD;
      has_rsp = (is_load && req_payload.last) ||
                req_payload.command == icl_pkg::CMD_READ_PRG ||
                req_payload.command == icl_pkg::CMD_READ_CHR;

      cur_pos = loading_ff ? pos_ff : '0;
      cur_tag = loading_ff ? tag_ff : 1'b1;
      for (int i = 0; i < 4; i++) begin
         cur_hdr[i] = loading_ff ? hdr_ff[i] : 8'd0;
         hdr_in[i]  = cur_hdr[i];
      end
      tag_in = cur_tag;
      if (cur_pos < PW'(4)) begin
         if (req_payload.data_byte != icl_pkg::TAG_BYTES[cur_pos[1:0]]) begin
            tag_in = 1'b0;
         end
      end else if (cur_pos < PW'(8)) begin
         hdr_in[cur_pos[1:0]] = req_payload.data_byte;
      end
      pos_in = (cur_pos == icl_pkg::POS_MAX) ? cur_pos : cur_pos + PW'(1);

      off       = cur_pos - PW'(icl_pkg::HEADER_BYTES);
      prg_bytes = PW'(cur_hdr[0]) << icl_pkg::PRG_BANK_SHIFT;
      chr_bytes = PW'(cur_hdr[1]) << icl_pkg::CHR_BANK_SHIFT;
      coff      = off - prg_bytes;
      prg_wr = cur_pos >= PW'(icl_pkg::HEADER_BYTES) && off < prg_bytes &&
               off < PW'(PRG_DEPTH);
      chr_wr = cur_pos >= PW'(icl_pkg::HEADER_BYTES) && !(off < prg_bytes) &&
               coff < chr_bytes && coff < PW'(MAX_CHR_BANKS << icl_pkg::CHR_BANK_SHIFT);

      total = PW'(icl_pkg::HEADER_BYTES) + (PW'(hdr_in[0]) << icl_pkg::PRG_BANK_SHIFT) +
              (PW'(hdr_in[1]) << icl_pkg::CHR_BANK_SHIFT);
      if (pos_in < PW'(4) || !tag_in) begin
         load_status = icl_pkg::ST_BAD_TAG;
      end else if ((hdr_in[3][3:2] & icl_pkg::NES2_CODE_MASK) != 2'd0) begin
         load_status = icl_pkg::ST_NES2;
      end else if ((hdr_in[2] & icl_pkg::TRAINER_BIT) != 8'd0) begin
         load_status = icl_pkg::ST_TRAINER;
      end else if (hdr_in[0] == 8'd0) begin
         load_status = icl_pkg::ST_NO_PRG;
      end else if (pos_in < total) begin
         load_status = icl_pkg::ST_TOO_SHORT;
      end else if ({1'b0, hdr_in[0]} > 9'(MAX_PRG_BANKS) ||
                   {1'b0, hdr_in[1]} > 9'(MAX_CHR_BANKS)) begin
         load_status = icl_pkg::ST_TOO_LARGE;
      end else begin
         load_status = icl_pkg::ST_OK;
      end

      loading_in = loading_ff;
      lprg_in    = lprg_ff;
      lchr_in    = lchr_ff;
      if (is_load) begin
         loading_in = !req_payload.last;
         if (req_payload.last && load_status == icl_pkg::ST_OK) begin
            lprg_in = hdr_in[0][LPW-1:0];
            lchr_in = hdr_in[1][LCW-1:0];
         end else if (req_payload.last || !loading_ff) begin
            lprg_in = '0;
            lchr_in = '0;
         end
      end

      prg_eff   = (lprg_ff == LPW'(1)) ?
                  {2'b00, req_payload.address[icl_pkg::PRG_BANK_SHIFT-1:0]} :
                  req_payload.address;
      prg_limit = RW'(lprg_ff) << icl_pkg::PRG_BANK_SHIFT;
      chr_limit = RW'(lchr_ff) << icl_pkg::CHR_BANK_SHIFT;
      prg_ok    = {1'b0, prg_eff} < prg_limit;
      chr_ok    = {1'b0, req_payload.address} < chr_limit;

      a_rsp_in = '0;
      if (is_load) begin
         a_rsp_in.status         = load_status;
         a_rsp_in.mapper_number  = (hdr_in[3] & icl_pkg::MAPPER_HI_MASK) |
                                   {4'd0, hdr_in[2][7:4]};
         a_rsp_in.mirroring      = ((hdr_in[2] & icl_pkg::FOUR_SCREEN_BIT) != 8'd0) ?
                                   icl_pkg::MIRROR_FOUR_SCREEN :
                                   (((hdr_in[2] & icl_pkg::VERTICAL_BIT) != 8'd0) ?
                                   icl_pkg::MIRROR_VERTICAL : icl_pkg::MIRROR_HORIZONTAL);
         a_rsp_in.prg_bank_count = hdr_in[0];
         a_rsp_in.chr_bank_count = hdr_in[1];
      end else if (req_payload.command == icl_pkg::CMD_READ_PRG) begin
         a_rsp_in.status = prg_ok ? icl_pkg::ST_OK : icl_pkg::ST_ADDR_RANGE;
      end else begin
         a_rsp_in.status = chr_ok ? icl_pkg::ST_OK : icl_pkg::ST_ADDR_RANGE;
      end

      a_move    = a_valid_ff && (!b_valid_ff || !rsp_stall);
      req_stall = a_valid_ff && !a_move;

      if (accept && has_rsp) begin
         a_valid_in = 1'b1;
      end else if (a_move) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end

      a_read_value = a_prg_ok_ff ? prg_rd_ff : (a_chr_ok_ff ? chr_rd_ff : 8'd0);
      b_rsp_in = b_rsp_ff;
      b_valid_in = b_valid_ff;
      if (a_move) begin
         b_valid_in          = 1'b1;
         b_rsp_in            = a_rsp_ff;
         b_rsp_in.read_value = a_read_value;
      end else if (b_valid_ff && !rsp_stall) begin
         b_valid_in = 1'b0;
      end

      rsp_valid   = b_valid_ff;
      rsp_payload = b_rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (accept && is_load && prg_wr) begin
         prg_mem[off[PRG_AW-1:0]] <= req_payload.data_byte;
      end
      if (accept && req_payload.command == icl_pkg::CMD_READ_PRG) begin
         prg_rd_ff <= prg_mem[prg_eff[PRG_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_load && chr_wr) begin
         chr_mem[coff[CHR_AW-1:0]] <= req_payload.data_byte;
      end
      if (accept && req_payload.command == icl_pkg::CMD_READ_CHR) begin
         chr_rd_ff <= chr_mem[req_payload.address[CHR_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         loading_ff <= 1'b0;
         tag_ff     <= 1'b1;
         lprg_ff    <= '0;
         lchr_ff    <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            hdr_ff[i] <= 8'd0;
         end
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         if (accept) begin
            loading_ff <= loading_in;
            lprg_ff    <= lprg_in;
            lchr_ff    <= lchr_in;
            if (is_load) begin
               pos_ff <= pos_in;
               tag_ff <= tag_in;
               for (int i = 0; i < 4; i++) begin
                  hdr_ff[i] <= hdr_in[i];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && has_rsp) begin
         a_rsp_ff    <= a_rsp_in;
         a_prg_ok_ff <= req_payload.command == icl_pkg::CMD_READ_PRG && prg_ok;
         a_chr_ok_ff <= req_payload.command == icl_pkg::CMD_READ_CHR && chr_ok;
      end
      b_rsp_ff <= b_rsp_in;
   end

endmodule

`default_nettype wire

@@ rtl/icl_checker.sv @@
// Port checker for the iNES cartridge loader, bound to its top level.
// Depends on icl_pkg and watches the top-level ports only.
`timescale 1ns / 1ps
`default_nettype none

module icl_port_checker (
   input wire              clock,
   input wire              reset,
   input wire              req_valid,
   input wire              req_stall,
   input icl_pkg::req_type req_payload,
   input wire              rsp_valid,
   input wire              rsp_stall,
   input icl_pkg::rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result item changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item present after reset");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != icl_pkg::ST_OK |-> rsp_payload.read_value == 8'd0)
      else $error("failed item carries read data");

   a_read_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == icl_pkg::ST_ADDR_RANGE |->
         rsp_payload.mapper_number == 8'd0 && rsp_payload.mirroring == 2'd0 &&
         rsp_payload.prg_bank_count == 8'd0 && rsp_payload.chr_bank_count == 8'd0)
      else $error("range error item carries header fields");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.command == icl_pkg::CMD_READ_PRG |=>
         ##1 rsp_valid)
      else $error("read item produced no result");

endmodule

bind ines_cartridge_loader icl_port_checker u_icl_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
